/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FOIE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define FOIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/foie_pkg.sv */
// Shared types and constants of the first-occurrence index encoder.
`default_nettype none

package foie_pkg;

  localparam int DICT_DEPTH_DEF = 64;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int KEY_FIELD_W    = 32;
  localparam int INDEX_W        = 6;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key_value;
    logic                   last_of_list;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] assigned_index;
    logic               is_first_occurrence;
    logic               table_full;
    logic               list_done;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic decided;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/foie_ctrl.sv */
// Controller state machine of the first-occurrence index encoder.
`default_nettype none

module foie_ctrl import foie_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE   = 2'b01,
    SEARCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SEARCH;
        end
      end
      SEARCH: begin
        if (!status.decided) begin
          cmd.step = 1'b1;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/foie_dp.sv */
// Datapath of the first-occurrence index encoder: dictionary memory, search and result.
`default_nettype none

module foie_dp import foie_pkg::*; #(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  in_word,
  input  wire cmd_t cmd,
  output status_t   status,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_word
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DICT_DEPTH);

  logic [KEY_WIDTH-1:0] mem [DICT_DEPTH];
  logic [KEY_WIDTH-1:0] key;
  logic                 last;
  logic [KEY_WIDTH-1:0] rdata;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic [AW-1:0]        cmp_idx;
  logic                 cmp_valid;

  logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_ext;
  logic [INDEX_W+AW-1:0]            hit_idx_ext;
  logic [INDEX_W+CW-1:0]            new_idx_ext;
  logic                             hit;
  logic                             room;
  out_t                             result;

  assign key_ext     = {{KEY_WIDTH{1'b0}}, in_word.key_value};
  assign hit_idx_ext = {{INDEX_W{1'b0}}, cmp_idx};
  assign new_idx_ext = {{INDEX_W{1'b0}}, count};
  assign hit         = cmp_valid && (rdata == key);
  assign room        = (count != DEPTH_C);

  assign status.decided  = hit || (ptr == count);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    result.list_done = last;
    if (hit) begin
      result.assigned_index      = hit_idx_ext[INDEX_W-1:0];
      result.is_first_occurrence = 1'b0;
      result.table_full          = 1'b0;
    end else if (room) begin
      result.assigned_index      = new_idx_ext[INDEX_W-1:0];
      result.is_first_occurrence = 1'b1;
      result.table_full          = 1'b0;
    end else begin
      result.assigned_index      = '0;
      result.is_first_occurrence = 1'b1;
      result.table_full          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rdata <= mem[ptr[AW-1:0]];
    end
    if (cmd.finish && !hit && room) begin
      mem[count[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= key_ext[KEY_WIDTH-1:0];
      last <= in_word.last_of_list;
      ptr  <= '0;
    end else if (cmd.step) begin
      ptr     <= ptr + CW'(1);
      cmp_idx <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (cmd.load) begin
        cmp_valid <= 1'b0;
      end else if (cmd.step) begin
        cmp_valid <= 1'b1;
      end
      if (cmd.finish) begin
        if (last) begin
          count <= '0;
        end else if (!hit && room) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= result;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/first_occurrence_index_encoder_core.sv */
// Top level of the first-occurrence index encoder.
// Each accepted word is compared against the entries stored in the current list, one entry
// per cycle through the single read port; the search ends on a hit or after the last entry.
// A new word is taken only once the search of the previous one has finished and its result
// has been registered; a stalled result holds back that finish.
// Reset clears the entry count, the controller state and the valid flags; no clearing pass is needed.
`default_nettype none

module first_occurrence_index_encoder_core import foie_pkg::*; #(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_word,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_word
);

  cmd_t    cmd;
  status_t status;

  foie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  foie_dp #(
    .DICT_DEPTH (DICT_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* hw/rtl/foie_checker.sv */
// Port-level assertions of the first-occurrence index encoder and their bind.
`default_nettype none
`include "assert_macros.svh"

module foie_checker import foie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_word
);

  logic full_idx_zero;

  assign full_idx_zero = (out_word.assigned_index == '0) && out_word.is_first_occurrence;

  `FOIE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  `FOIE_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)
  `FOIE_ASSERT_IMPL(a_full_zero_index, clk, rst, out_valid && out_word.table_full, full_idx_zero)
  `FOIE_ASSERT_IMPL(a_hit_not_full, clk, rst, out_valid && !out_word.is_first_occurrence, !out_word.table_full)

endmodule

bind first_occurrence_index_encoder_core foie_checker u_foie_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the first-occurrence index encoder core.
module testbench import foie_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = DICT_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1400;
  localparam int QUIET_FROM   = ITEM_TARGET - 200;
  localparam int WATCH_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = DEPTH + 8;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_word;
  logic out_valid;
  logic out_stall;
  out_t out_word;

  logic [KEY_FIELD_W-1:0] dict_keys [DEPTH];
  int   dict_count = 0;
  out_t pending_results[$];
  int   error_count = 0;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  bit   in_gaps_on = 0;
  bit   out_stalls_on = 0;

  first_occurrence_index_encoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_t encode_key(in_t w);
    out_t r;
    int   slot;
    slot = -1;
    for (int k = 0; k < dict_count; k++) begin
      if (slot < 0 && dict_keys[k] == w.key_value) slot = k;
    end
    r.assigned_index      = '0;
    r.is_first_occurrence = 1'b1;
    r.table_full          = 1'b0;
    r.list_done           = w.last_of_list;
    if (slot >= 0) begin
      r.assigned_index      = INDEX_W'(slot);
      r.is_first_occurrence = 1'b0;
    end else if (dict_count < DEPTH) begin
      dict_keys[dict_count] = w.key_value;
      r.assigned_index      = INDEX_W'(dict_count);
      dict_count++;
    end else begin
      r.table_full = 1'b1;
    end
    if (w.last_of_list) dict_count = 0;
    return r;
  endfunction

  task automatic queue_result(input out_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic send_word(input logic [KEY_FIELD_W-1:0] key, input logic last);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_word.key_value    = key;
    in_word.last_of_list = last;
    in_valid             = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_result(encode_key(in_word));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_extremes();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    drain_results();
  endtask

  task automatic test_full_dictionary();
    logic [KEY_FIELD_W-1:0] stored [DEPTH];
    logic [KEY_FIELD_W-1:0] extra;
    for (int i = 0; i < DEPTH; i++) begin
      stored[i] = {i[7:0], 24'($urandom)};
      send_word(stored[i], 1'b0);
    end
    extra = {8'hF0, 24'($urandom)};
    send_word(extra, 1'b0);
    send_word(extra, 1'b0);
    send_word(stored[DEPTH-1], 1'b0);
    send_word(stored[0], 1'b0);
    send_word({8'hF1, 24'($urandom)}, 1'b1);
    send_word(stored[5], 1'b1);
    drain_results();
  endtask

  task automatic test_random_lists();
    logic [KEY_FIELD_W-1:0] pool [16];
    logic [KEY_FIELD_W-1:0] key;
    int  list_len;
    int  pool_size;
    bit  deep_list;
    while (words_sent < ITEM_TARGET) begin
      deep_list = ($urandom_range(0, 15) == 0);
      list_len  = deep_list ? $urandom_range(70, 100) : $urandom_range(1, 24);
      pool_size = $urandom_range(1, 16);
      for (int p = 0; p < pool_size; p++) begin
        pool[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
      end
      for (int i = 0; i < list_len; i++) begin
        if (words_sent >= QUIET_FROM) begin
          in_gaps_on    = 1'b0;
          out_stalls_on = 1'b0;
        end else if (i == 0) begin
          in_gaps_on    = ($urandom_range(0, 3) != 0);
          out_stalls_on = ($urandom_range(0, 3) != 0);
        end
        if (deep_list)
          key = ($urandom_range(0, 4) == 0) ? pool[$urandom_range(0, pool_size - 1)] : $urandom;
        else
          key = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
        send_word(key, i == list_len - 1);
      end
    end
    drain_results();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!out_stalls_on) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      out_stall = (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $error("unexpected result word: %p", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.assigned_index !== want.assigned_index) begin
          error_count++;
          $error("assigned_index: expected %0d, got %0d",
                 want.assigned_index, out_word.assigned_index);
        end
        if (out_word.is_first_occurrence !== want.is_first_occurrence) begin
          error_count++;
          $error("is_first_occurrence: expected %0b, got %0b",
                 want.is_first_occurrence, out_word.is_first_occurrence);
        end
        if (out_word.table_full !== want.table_full) begin
          error_count++;
          $error("table_full: expected %0b, got %0b", want.table_full, out_word.table_full);
        end
        if (out_word.list_done !== want.list_done) begin
          error_count++;
          $error("list_done: expected %0b, got %0b", want.list_done, out_word.list_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_full_dictionary();
    test_random_lists();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
